// ----- src/fupd_pkg.sv -----
`default_nettype none

package fupd_pkg;

  // Longest extension, in bytes, that is kept for the markdown check.
  localparam int MAX_EXTENSION_CHARS = 8;
  localparam int EXT_LEN_W = $clog2(MAX_EXTENSION_CHARS + 1);
  localparam int EXT_IDX_W = $clog2(MAX_EXTENSION_CHARS);

  // Transactions that may wait between the front and the back part.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int PREFIX_LEN = 8;
  localparam logic [0:PREFIX_LEN-1][7:0] URL_PREFIX = "file:///";

  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Stop codes of the front part.
  localparam logic [1:0] SCAN_RUN    = 2'd0;
  localparam logic [1:0] SCAN_STOP   = 2'd1;
  localparam logic [1:0] SCAN_REJECT = 2'd2;

  // Escape phases of the front part.
  localparam logic [1:0] ESC_NONE    = 2'd0;
  localparam logic [1:0] ESC_PERCENT = 2'd1;
  localparam logic [1:0] ESC_DIGIT   = 2'd2;

  // Extension flags.
  localparam logic [2:0] FLAG_NAME_FRONT = 3'b001;
  localparam logic [2:0] FLAG_SEP_AFTER  = 3'b010;
  localparam logic [2:0] FLAG_OVERFLOW   = 3'b100;

  // Work that one input transaction hands to the back part: up to three
  // path bytes in order, then an optional verdict.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            verdict;
    logic            fail;
  } bundle_t;

  typedef logic [MAX_EXTENSION_CHARS-1:0][7:0] ext_chars_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Compares the stored extension with one pattern of n characters,
  // first character in the top byte of pat.
  function automatic logic ext_is(input ext_chars_t chars, input logic [EXT_LEN_W-1:0] len,
                                  input logic [63:0] pat, input int n);
    logic ok;
    ok = (len == EXT_LEN_W'(n));
    for (int i = 0; i < 8; i++) begin
      if (i < n && chars[i] != pat[63-8*i -: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic ext_is_markdown(input ext_chars_t chars,
                                           input logic [EXT_LEN_W-1:0] len);
    return ext_is(chars, len, {"md", 48'd0}, 2) ||
           ext_is(chars, len, "markdown", 8) ||
           ext_is(chars, len, {"mdown", 24'd0}, 5) ||
           ext_is(chars, len, {"mkd", 40'd0}, 3) ||
           ext_is(chars, len, {"mdwn", 32'd0}, 4);
  endfunction

endpackage

`default_nettype wire

// ----- src/fupd_front.sv -----
`default_nettype none

module fupd_front
  import fupd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  input  wire logic       queue_full,
  output logic            push,
  output bundle_t         push_data
);

  logic [3:0] prefix_position, prefix_position_next;
  logic [1:0] escape_phase, escape_phase_next;
  logic [7:0] held_hex_char, held_hex_char_next;
  logic [1:0] stopped_or_rejected, stopped_or_rejected_next;

  logic       take;
  bundle_t    bun;
  logic [1:0] cnt;
  logic       do_plain;
  logic [7:0] decoded;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  // Classify the byte: prefix match, escape decode, stop and reject.
  always_comb begin
    prefix_position_next     = prefix_position;
    escape_phase_next        = escape_phase;
    held_hex_char_next       = held_hex_char;
    stopped_or_rejected_next = stopped_or_rejected;
    bun      = '0;
    cnt      = 2'd0;
    do_plain = 1'b0;
    decoded  = {hex_val(held_hex_char), hex_val(in_byte)};

    if (stopped_or_rejected != SCAN_RUN) begin
      // Ignore the rest of the string.
    end else if (prefix_position < 4'(PREFIX_LEN)) begin
      if (in_byte != URL_PREFIX[prefix_position[2:0]]) begin
        stopped_or_rejected_next = SCAN_REJECT;
      end else begin
        prefix_position_next = prefix_position + 4'd1;
      end
    end else if (escape_phase == ESC_PERCENT) begin
      if (is_hex(in_byte) && !end_of_string) begin
        held_hex_char_next = in_byte;
        escape_phase_next  = ESC_DIGIT;
      end else begin
        escape_phase_next = ESC_NONE;
        bun.bytes[cnt]    = CH_PERCENT;
        cnt               = cnt + 2'd1;
        do_plain          = 1'b1;
      end
    end else if (escape_phase == ESC_DIGIT) begin
      escape_phase_next = ESC_NONE;
      if (is_hex(in_byte)) begin
        if (decoded == CH_NUL) begin
          stopped_or_rejected_next = SCAN_REJECT;
        end else begin
          bun.bytes[cnt] = decoded;
          cnt            = cnt + 2'd1;
        end
      end else begin
        // The held digit is an ordinary byte and goes out as it is.
        bun.bytes[cnt] = CH_PERCENT;
        cnt            = cnt + 2'd1;
        bun.bytes[cnt] = held_hex_char;
        cnt            = cnt + 2'd1;
        do_plain       = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // Ordinary path byte with no escape pending.
    if (do_plain) begin
      if (in_byte == CH_HASH || in_byte == CH_QUESTION) begin
        stopped_or_rejected_next = SCAN_STOP;
      end else if (in_byte == CH_PERCENT && !end_of_string) begin
        escape_phase_next = ESC_PERCENT;
      end else if (in_byte == CH_NUL) begin
        stopped_or_rejected_next = SCAN_REJECT;
      end else begin
        bun.bytes[cnt] = (in_byte == CH_SLASH) ? CH_BACKSLASH : in_byte;
        cnt            = cnt + 2'd1;
      end
    end

    bun.count = cnt;

    // The final byte closes the string and clears all state.
    if (end_of_string) begin
      bun.verdict = 1'b1;
      bun.fail    = (stopped_or_rejected_next == SCAN_REJECT) ||
                    (prefix_position_next < 4'(PREFIX_LEN));
      prefix_position_next     = '0;
      escape_phase_next        = ESC_NONE;
      held_hex_char_next       = '0;
      stopped_or_rejected_next = SCAN_RUN;
    end
  end

  assign push      = take && (cnt != 2'd0 || end_of_string);
  assign push_data = bun;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_position     <= '0;
      escape_phase        <= ESC_NONE;
      held_hex_char       <= '0;
      stopped_or_rejected <= SCAN_RUN;
    end else if (take) begin
      prefix_position     <= prefix_position_next;
      escape_phase        <= escape_phase_next;
      held_hex_char       <= held_hex_char_next;
      stopped_or_rejected <= stopped_or_rejected_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/fupd_queue.sv -----
`default_nettype none

module fupd_queue
  import fupd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         empty,
  output bundle_t      head
);

  bundle_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W:0]   wr_ptr;
  logic [QUEUE_PTR_W:0]   rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[QUEUE_PTR_W] != rd_ptr[QUEUE_PTR_W]) &&
                 (wr_ptr[QUEUE_PTR_W-1:0] == rd_ptr[QUEUE_PTR_W-1:0]);
  assign head  = entries[rd_ptr[QUEUE_PTR_W-1:0]];

  // Pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr[QUEUE_PTR_W-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/fupd_back.sv -----
`default_nettype none

module fupd_back
  import fupd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    queue_empty,
  input  wire bundle_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic         kind,
  output logic [7:0]   path_byte,
  output logic         accepted,
  output logic         last_of_run
);

  logic                 path_nonempty, path_nonempty_next;
  logic                 dot_seen, dot_seen_next;
  ext_chars_t           extension_chars;
  logic [EXT_LEN_W-1:0] extension_length, extension_length_next;
  logic [2:0]           extension_flags, extension_flags_next;
  logic                 previous_was_backslash, previous_was_backslash_next;
  logic [1:0]           idx;

  logic       step;
  logic       has_byte;
  logic [7:0] cur_byte;
  logic       is_last;
  logic       verdict_acc;
  logic       char_we;

  assign step     = !queue_empty && (!out_valid || out_ready);
  assign has_byte = (idx < head.count);
  assign cur_byte = has_byte ? head.bytes[idx] : 8'd0;
  assign is_last  = has_byte ? (idx == head.count - 2'd1) && !head.verdict : 1'b1;
  assign pop      = step && is_last;

  assign verdict_acc = !head.fail && path_nonempty && dot_seen &&
                       (extension_flags == FLAG_NAME_FRONT) &&
                       ext_is_markdown(extension_chars, extension_length);

  // Extension tracking for one path byte, or clearing after a verdict.
  always_comb begin
    path_nonempty_next          = path_nonempty;
    dot_seen_next               = dot_seen;
    extension_length_next       = extension_length;
    extension_flags_next        = extension_flags;
    previous_was_backslash_next = previous_was_backslash;
    char_we                     = 1'b0;
    if (has_byte) begin
      if (cur_byte == CH_DOT) begin
        dot_seen_next         = 1'b1;
        extension_flags_next  = (path_nonempty && !previous_was_backslash) ?
                                FLAG_NAME_FRONT : 3'b000;
        extension_length_next = '0;
      end else if (dot_seen) begin
        if (cur_byte == CH_BACKSLASH) begin
          extension_flags_next = extension_flags | FLAG_SEP_AFTER;
        end else if (extension_length < EXT_LEN_W'(MAX_EXTENSION_CHARS)) begin
          char_we               = 1'b1;
          extension_length_next = extension_length + 1'b1;
        end else begin
          extension_flags_next = extension_flags | FLAG_OVERFLOW;
        end
      end
      previous_was_backslash_next = (cur_byte == CH_BACKSLASH);
      path_nonempty_next          = 1'b1;
    end else begin
      path_nonempty_next          = 1'b0;
      dot_seen_next               = 1'b0;
      extension_length_next       = '0;
      extension_flags_next        = 3'b000;
      previous_was_backslash_next = 1'b0;
    end
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      path_nonempty          <= 1'b0;
      dot_seen               <= 1'b0;
      extension_length       <= '0;
      extension_flags        <= 3'b000;
      previous_was_backslash <= 1'b0;
      idx                    <= 2'd0;
      out_valid              <= 1'b0;
    end else begin
      if (step) begin
        path_nonempty          <= path_nonempty_next;
        dot_seen               <= dot_seen_next;
        extension_length       <= extension_length_next;
        extension_flags        <= extension_flags_next;
        previous_was_backslash <= previous_was_backslash_next;
        idx                    <= is_last ? 2'd0 : idx + 2'd1;
        out_valid              <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload and extension characters.
  always_ff @(posedge clk) begin
    if (step) begin
      kind        <= !has_byte;
      path_byte   <= cur_byte;
      accepted    <= has_byte ? 1'b0 : verdict_acc;
      last_of_run <= is_last;
      if (char_we) begin
        extension_chars[extension_length[EXT_IDX_W-1:0]] <= lower_ascii(cur_byte);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/file_url_path_decoder.sv -----
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid, in_ready  | in_byte, end_of_string
// output  | out       | out_valid, out_ready| kind, path_byte, accepted, last_of_run
//
// The front part takes one URI byte per cycle while its four-entry queue has room.
// The back part sends one result per cycle while the output is not stalled, so a byte
// that causes k results (k is at most four) holds the back part until all k are sent;
// the results are built from its queue entry and held in the output register.
// Reset clears all control state.
// A stalled output fills the queue, and only then is in_ready dropped.
`default_nettype none

module file_url_path_decoder
  import fupd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      path_byte,
  output logic            accepted,
  output logic            last_of_run
);

  logic    push;
  bundle_t push_data;
  logic    queue_full;
  logic    queue_empty;
  logic    pop;
  bundle_t head;

  // Prefix check and escape decoding.
  fupd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  // Queue of decoded transactions.
  fupd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  // Result sequencing and extension check.
  fupd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .path_byte   (path_byte),
    .accepted    (accepted),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
